@@ rtl/skt_pkg.sv @@
`timescale 1ns / 1ps
package skt_pkg;

  localparam int CAPACITY    = 16;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int KEY_W       = 32;
  localparam int ACT_W       = 3;
  localparam int POS_W       = 4;
  localparam int STAT_W      = 3;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_LOOKUP = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_READ   = 3'd4
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_ABSENT    = 3'd2,
    STAT_DUPLICATE = 3'd3,
    STAT_RANGE     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_EXEC = 3'b100
  } state_e;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic load;     // capture the request beat
    logic compare;  // register per-entry compare results
    logic execute;  // update table and load the result register
  } skt_cmd_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic res_busy; // result register holds a beat that is not taken this cycle
  } skt_stat_t;

endpackage

@@ rtl/skt_ctrl.sv @@
`timescale 1ns / 1ps
module skt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output skt_pkg::skt_cmd_t cmd_o,
  input  skt_pkg::skt_stat_t stat_i
);
  import skt_pkg::*;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_o.load    = 1'b0;
    cmd_o.compare = 1'b0;
    cmd_o.execute = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd_o.compare = 1'b1;
        state_d       = ST_EXEC;
      end
      ST_EXEC: begin
        // hold until the result register can take a new beat
        if (!stat_i.res_busy) begin
          cmd_o.execute = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/skt_datapath.sv @@
`timescale 1ns / 1ps
module skt_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  skt_pkg::skt_cmd_t                   cmd_i,
  input  logic [skt_pkg::IN_TDATA_W-1:0]      in_tdata_i,
  output logic                                out_tvalid_o,
  input  logic                                out_tready_i,
  output logic [skt_pkg::OUT_TDATA_W-1:0]     out_tdata_o,
  output skt_pkg::skt_stat_t                  stat_o
);
  import skt_pkg::*;

  // captured request
  action_e                 act_q;
  logic signed [KEY_W-1:0] key_q;
  logic [POS_W-1:0]        pos_q;

  // table storage
  logic signed [KEY_W-1:0] entry_q [CAPACITY];
  logic signed [KEY_W-1:0] entry_d [CAPACITY];
  logic signed [KEY_W-1:0] up_w    [CAPACITY];
  logic signed [KEY_W-1:0] dn_w    [CAPACITY];
  logic [CNT_W-1:0]        count_q, count_d;

  // compare stage
  logic [CAPACITY-1:0] lt_q, lt_d, eq_q, eq_d;

  // result register
  logic                    res_valid_q;
  status_e                 res_status_q, res_status_d;
  logic                    res_found_q, res_found_d;
  logic signed [KEY_W-1:0] res_value_q, res_value_d;
  logic [CNT_W-1:0]        res_count_q;
  logic                    res_full_q;

  logic [CNT_W-1:0] slot;
  logic             hit;
  logic             full;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_e'(in_tdata_i[ACT_W-1:0]);
      key_q <= in_tdata_i[ACT_W +: KEY_W];
      pos_q <= in_tdata_i[ACT_W+KEY_W +: POS_W];
    end
  end

  // one comparator per entry, only live entries count
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt_d[i] = (CNT_W'(i) < count_q) && (entry_q[i] < key_q);
      eq_d[i] = (CNT_W'(i) < count_q) && (entry_q[i] == key_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.compare) begin
      lt_q <= lt_d;
      eq_q <= eq_d;
    end
  end

  // neighbor views of the table for shifting
  always_comb begin
    up_w[0]          = entry_q[0];
    dn_w[CAPACITY-1] = entry_q[CAPACITY-1];
    for (int i = 1; i < CAPACITY; i++) begin
      up_w[i] = entry_q[i-1];
    end
    for (int i = 0; i < CAPACITY - 1; i++) begin
      dn_w[i] = entry_q[i+1];
    end
  end

  assign slot = CNT_W'($countones(lt_q));
  assign hit  = |eq_q;
  assign full = (count_q == CNT_W'(CAPACITY));

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      entry_d[i] = entry_q[i];
    end
    count_d      = count_q;
    res_status_d = STAT_OK;
    res_found_d  = 1'b0;
    res_value_d  = '0;
    case (act_q)
      ACT_INSERT: begin
        if (full) begin
          res_status_d = STAT_FULL;
        end else if (hit) begin
          res_status_d = STAT_DUPLICATE;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (CNT_W'(i) == slot) begin
              entry_d[i] = key_q;
            end else if (CNT_W'(i) > slot && CNT_W'(i) <= count_q) begin
              entry_d[i] = up_w[i];
            end
          end
          count_d = count_q + 1'b1;
        end
      end
      ACT_DELETE: begin
        if (!hit) begin
          res_status_d = STAT_ABSENT;
        end else begin
          res_found_d = 1'b1;
          for (int i = 0; i < CAPACITY; i++) begin
            if (CNT_W'(i) >= slot && CNT_W'(i) + 1'b1 < count_q) begin
              entry_d[i] = dn_w[i];
            end
          end
          count_d = count_q - 1'b1;
        end
      end
      ACT_LOOKUP: begin
        if (hit) begin
          res_found_d = 1'b1;
          res_value_d = key_q;
        end else begin
          res_status_d = STAT_ABSENT;
        end
      end
      ACT_CLEAR: begin
        count_d = '0;
      end
      ACT_READ: begin
        if ({1'b0, pos_q} < count_q) begin
          res_value_d = entry_q[pos_q];
        end else begin
          res_status_d = STAT_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      for (int i = 0; i < CAPACITY; i++) begin
        entry_q[i] <= entry_d[i];
      end
      res_status_q <= res_status_d;
      res_found_q  <= res_found_d;
      res_value_q  <= res_value_d;
      res_count_q  <= count_d;
      res_full_q   <= (count_d == CNT_W'(CAPACITY));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cmd_i.execute) begin
        count_q     <= count_d;
        res_valid_q <= 1'b1;
      end else if (out_tready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.res_busy = res_valid_q & ~out_tready_i;
  assign out_tvalid_o    = res_valid_q;
  assign out_tdata_o     = {6'b0, res_full_q, res_count_q, res_value_q,
                            res_found_q, res_status_q};

endmodule

@@ rtl/sorted_key_table_unit.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Beat fields (lowest bit up)
// s_axis    in   action[2:0], key[34:3], position[38:35], zero fill to 40 bits
// m_axis    out  status[2:0], found[3], value[35:4], count[40:36],
//                is_full[41], zero fill to 48 bits
//
// One request is in flight at a time: accept, compare, execute. The next
// request is taken only once the previous one has executed; the registered
// compare stage across all table entries lies between accept and execute.
// The result sits in an output register, so a new request is accepted while
// the previous result waits; execute holds while that register is still
// occupied. Reset empties the table (count to zero).
module sorted_key_table_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // action, key, position
  input  logic [skt_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // status, found, value, count, is_full
  output logic [skt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o
);
  import skt_pkg::*;

  skt_cmd_t  cmd;
  skt_stat_t stat;

  // sequencer: one-hot state, drives load/compare/execute
  skt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  // table, per-entry comparators, shift network and result register
  skt_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .in_tdata_i   (s_axis_tdata_i),
    .out_tvalid_o (m_axis_tvalid_o),
    .out_tready_i (m_axis_tready_i),
    .out_tdata_o  (m_axis_tdata_o),
    .stat_o       (stat)
  );

endmodule

@@ dv/sorted_key_table_unit_tb.sv @@
`timescale 1ns / 1ps
module sorted_key_table_unit_tb;
  import skt_pkg::*;

  localparam int          CLK_HALF     = 4;
  localparam int          RAND_ITEMS   = 550;
  localparam int          DRAIN_CYCLES = 24;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          MAX_REPORTS  = 10;
  localparam logic [2:0]  ACT_CODE_MAX = 3'((1 << ACT_W) - 1);

  typedef struct packed {
    status_e            status;
    logic               found;
    logic signed [31:0] value;
    logic [CNT_W-1:0]   count;
    logic               is_full;
  } reply_t;

  // Shadow copy of the sorted table plus the queue of replies it predicts.
  class table_scoreboard;
    logic signed [KEY_W-1:0] keys [CAPACITY];
    int unsigned             n_keys;
    reply_t                  reply_q[$];
    int                      mismatches;

    function new();
      n_keys     = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return reply_q.size();
    endfunction

    // Apply one accepted request to the shadow table and queue its reply.
    function void note_request(logic [ACT_W-1:0] act, logic signed [KEY_W-1:0] key,
                               logic [POS_W-1:0] pos);
      int unsigned slot;
      bit          hit;
      reply_t      r;
      slot = 0;
      r    = '0;
      while (slot < n_keys && keys[slot] < key) slot++;
      hit = (slot < n_keys) && (keys[slot] == key);
      r.status = STAT_OK;
      case (act)
        ACT_INSERT: begin
          if (n_keys >= CAPACITY) begin
            r.status = STAT_FULL;
          end else if (hit) begin
            r.status = STAT_DUPLICATE;
          end else begin
            for (int unsigned i = n_keys; i > slot; i--) keys[i] = keys[i-1];
            keys[slot] = key;
            n_keys++;
          end
        end
        ACT_DELETE: begin
          if (!hit) begin
            r.status = STAT_ABSENT;
          end else begin
            r.found = 1'b1;
            for (int unsigned i = slot + 1; i < n_keys; i++) keys[i-1] = keys[i];
            n_keys--;
          end
        end
        ACT_LOOKUP: begin
          if (hit) begin
            r.found = 1'b1;
            r.value = keys[slot];
          end else begin
            r.status = STAT_ABSENT;
          end
        end
        ACT_CLEAR: n_keys = 0;
        ACT_READ: begin
          if (pos < n_keys) r.value = keys[pos];
          else              r.status = STAT_RANGE;
        end
        default: ;  // unused codes leave the table alone
      endcase
      r.count   = CNT_W'(n_keys);
      r.is_full = (n_keys >= CAPACITY);
      reply_q.push_back(r);
    endfunction

    // Compare one reply beat against the oldest prediction.
    function void check_reply(logic [OUT_TDATA_W-1:0] beat);
      reply_t got;
      reply_t want;
      got.status  = status_e'(beat[2:0]);
      got.found   = beat[3];
      got.value   = beat[35:4];
      got.count   = beat[40:36];
      got.is_full = beat[41];
      if (reply_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected reply beat %h", beat);
        return;
      end
      want = reply_q.pop_front();
      if (got.status !== want.status || got.found !== want.found ||
          got.value !== want.value || got.count !== want.count ||
          got.is_full !== want.is_full) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"reply mismatch: exp st=%0d fd=%0d val=%0d cnt=%0d full=%0d,",
                    " got st=%0d fd=%0d val=%0d cnt=%0d full=%0d"},
                   want.status, want.found, want.value, want.count, want.is_full,
                   got.status, got.found, got.value, got.count, got.is_full);
      end
    endfunction
  endclass

  logic                   clk_i    = 1'b0;
  logic                   rst_n    = 1'b0;
  logic                   s_valid  = 1'b0;
  logic [IN_TDATA_W-1:0]  s_data   = '0;
  logic                   m_ready  = 1'b0;
  logic                   s_ready;
  logic                   m_valid;
  logic [OUT_TDATA_W-1:0] m_data;

  table_scoreboard sb = new();
  int              cycles = 0;

  sorted_key_table_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[sorted_key_table_unit] ERROR");
      $finish;
    end
  end

  // Receiver: stall on a 16-bit pattern that is redrawn each period.
  logic [15:0] stall_pat;
  logic [3:0]  pat_idx;
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      m_ready   <= 1'b0;
      stall_pat <= 16'hFFFF;
      pat_idx   <= '0;
    end else begin
      pat_idx <= pat_idx + 1'b1;
      m_ready <= stall_pat[pat_idx];
      if (pat_idx == 4'hF) begin
        case ($urandom_range(0, 3))
          0:       stall_pat <= 16'hFFFF;
          1:       stall_pat <= 16'($urandom) & 16'($urandom) | 16'h0001;
          default: stall_pat <= 16'($urandom) | 16'h0001;
        endcase
      end
    end
  end

  // Check every reply beat taken by the receiver.
  always @(posedge clk_i) begin
    if (rst_n && m_valid && m_ready) sb.check_reply(m_data);
  end

  // Present one request beat and hold it until the block takes it.
  task automatic send_request(logic [ACT_W-1:0] act, logic signed [KEY_W-1:0] key,
                              logic [POS_W-1:0] pos);
    s_valid <= 1'b1;
    s_data  <= {1'b0, pos, key, act};
    do @(posedge clk_i); while (!s_ready);
    sb.note_request(act, key, pos);
  endtask

  task automatic wait_replies_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Mostly a narrow key window so inserts collide and deletes hit.
  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed(32'($urandom_range(0, 40))) - 32'sd20;
    endcase
  endfunction

  function automatic logic [ACT_W-1:0] pick_action();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return ACT_INSERT;
    if (r < 60) return ACT_DELETE;
    if (r < 75) return ACT_LOOKUP;
    if (r < 95) return ACT_READ;
    if (r < 98) return ACT_CLEAR;
    return 3'($urandom_range(ACT_READ + 1, ACT_CODE_MAX));
  endfunction

  initial begin
    int burst_left;
    int gap;
    burst_left = 0;
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-table misses, key extremes, duplicates, range, unused codes, clear.
    send_request(ACT_LOOKUP, 32'sd5, 4'd0);
    send_request(ACT_READ,   32'sd0, 4'd0);
    send_request(ACT_DELETE, 32'sd5, 4'd0);
    send_request(ACT_INSERT, 32'sh8000_0000, 4'hF);
    send_request(ACT_INSERT, 32'sh7FFF_FFFF, 4'h0);
    send_request(ACT_INSERT, 32'sd0, 4'd0);
    send_request(ACT_INSERT, -32'sd1, 4'd0);
    send_request(ACT_INSERT, 32'sd0, 4'd0);
    send_request(ACT_LOOKUP, 32'sh8000_0000, 4'd0);
    send_request(ACT_LOOKUP, 32'sh7FFF_FFFF, 4'd0);
    send_request(ACT_LOOKUP, 32'sd7, 4'd0);
    send_request(ACT_READ,   32'sd0, 4'd0);
    send_request(ACT_READ,   32'sd0, 4'd3);
    send_request(ACT_READ,   32'sd0, 4'd4);
    send_request(ACT_READ,   32'sd0, 4'hF);
    send_request(ACT_DELETE, 32'sd0, 4'd0);
    send_request(ACT_DELETE, 32'sd0, 4'd0);
    send_request(ACT_READ + 3'd1, 32'sh7FFF_FFFF, 4'hF);
    send_request(ACT_CODE_MAX, 32'sh8000_0000, 4'd0);
    send_request(ACT_CLEAR,  32'sd0, 4'd0);
    send_request(ACT_LOOKUP, -32'sd1, 4'd0);
    send_request(ACT_READ,   32'sd0, 4'd0);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      // Pause the sender until every reply is home.
      if (n == 200 || n == 450) begin
        s_valid <= 1'b0;
        wait_replies_drained();
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          s_valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
      // Fill bursts drive the table to full and past it.
      if (n % 150 == 75) begin
        for (int f = 0; f < 20; f++) send_request(ACT_INSERT, $urandom, 4'($urandom));
        send_request(ACT_READ, 32'($urandom), 4'hF);
      end else begin
        send_request(pick_action(), pick_key(), 4'($urandom));
      end
    end

    s_valid <= 1'b0;
    wait_replies_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[sorted_key_table_unit] OK");
    end else begin
      $display("[sorted_key_table_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/skt_pkg.sv
rtl/skt_ctrl.sv
rtl/skt_datapath.sv
rtl/sorted_key_table_unit.sv
dv/sorted_key_table_unit_tb.sv
